/* src/iirdf2_pkg.sv */
// ----------------------------------------------------------------------------
// iirdf2_pkg
// Shared types, widths and helpers for the direct form II IIR filter.
// ----------------------------------------------------------------------------
package iirdf2_pkg;

    localparam int ORDER    = 2;                        // filter order, 1..2
    localparam int TAPS     = (ORDER < 2) ? ORDER : 2;  // taps with coefficients
    localparam int SAMPLE_W = 16;                       // Q1.15
    localparam int COEF_W   = 18;                       // Q4.14
    localparam int STATE_W  = 20;                       // Q5.15
    localparam int PROD_W   = COEF_W + STATE_W;
    localparam int ACC_W    = PROD_W + 2;               // three products summed
    localparam int FRAC_SH  = 14;
    localparam int RND_W    = ACC_W - FRAC_SH;
    localparam int IDX_W    = 3;
    localparam int OUT_TD_W = 24;                       // sample_out + saturated, byte padded
    localparam int STEP_W   = 3;

    localparam logic [IDX_W-1:0] REG_FB_GAIN_0 = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FB_COEF_1 = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_FB_COEF_2 = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_FF_COEF_0 = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_FF_COEF_1 = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_FF_COEF_2 = IDX_W'(5);

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_SH);

    localparam logic signed [RND_W-1:0] W_HI = RND_W'((1 << (STATE_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] W_LO = ~W_HI;
    localparam logic signed [RND_W-1:0] Y_HI = RND_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] Y_LO = ~Y_HI;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_load;
    } mac_ctrl_t;

    // Round half up and drop the fraction bits of the extra product scaling.
    function automatic logic signed [RND_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        t = acc + $signed(ACC_W'(1) << (FRAC_SH - 1));
        return t[ACC_W-1:FRAC_SH];
    endfunction

endpackage

/* src/iir_direct_form_ii_filter.sv */
// Flow: an input beat starts sequencer steps 0..7; the result is registered to
//   m_tvalid when the output is free. A new sample is accepted only when idle,
//   as the single 18x20 multiplier computes the six products in turn.
// The result register lets the next sample enter while a result waits.
// Reset (rst_n low, async): coefficients to unity gain / zero taps, delay line
//   cleared, no result pending.
// ----------------------------------------------------------------------------
// iir_direct_form_ii_filter
// Direct form II IIR filter with a sequenced shared multiply-accumulate.
// ----------------------------------------------------------------------------
module iir_direct_form_ii_filter
    import iirdf2_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,    // [15:0] sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_TD_W-1:0]   m_tdata,    // [15:0] sample_out, [16] saturated, rest zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [COEF_W-1:0]     cfg_data
);

    state_t                    state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic signed [COEF_W-1:0]  fb_coef_reg [3];
    logic signed [COEF_W-1:0]  ff_coef_reg [3];
    logic signed [STATE_W-1:0] dl_reg [ORDER];
    logic signed [STATE_W-1:0] tap_op [2];
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [STATE_W-1:0] w_reg;
    logic                      wclip_reg;
    logic                      m_valid_reg;
    logic [SAMPLE_W-1:0]       y_out_reg;
    logic                      sat_out_reg;

    mac_ctrl_t                 mac_ctrl;
    logic signed [COEF_W-1:0]  mac_coef;
    logic signed [STATE_W-1:0] mac_opnd;
    logic signed [ACC_W-1:0]   acc;
    logic signed [RND_W-1:0]   rnd;
    logic signed [STATE_W-1:0] w_sat;
    logic                      w_clip;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                      y_clip;
    logic                      s_accept;
    logic                      w_load;
    logic                      out_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Taps without a delay element behave as zero.
    for (genvar i = 0; i < 2; i++)
    begin : g_tap
        if (i < TAPS)
        begin : g_on
            assign tap_op[i] = dl_reg[i];
        end
        else
        begin : g_off
            assign tap_op[i] = '0;
        end
    end

    iirdf2_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .coef (mac_coef),
        .opnd (mac_opnd),
        .acc  (acc)
    );

    // Round and saturate the accumulator for both w and y.
    always_comb
    begin
        rnd    = rnd_shift(acc);
        w_clip = (rnd > W_HI) || (rnd < W_LO);
        if (rnd > W_HI)
            w_sat = W_HI[STATE_W-1:0];
        else if (rnd < W_LO)
            w_sat = W_LO[STATE_W-1:0];
        else
            w_sat = rnd[STATE_W-1:0];
        y_clip = (rnd > Y_HI) || (rnd < Y_LO);
        if (rnd > Y_HI)
            y_sat = Y_HI[SAMPLE_W-1:0];
        else if (rnd < Y_LO)
            y_sat = Y_LO[SAMPLE_W-1:0];
        else
            y_sat = rnd[SAMPLE_W-1:0];
    end

    // Sequencer: products issue in steps 0..5, accumulate in steps 1..6 via the product register.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mac_ctrl   = '0;
        mac_coef   = fb_coef_reg[0];
        mac_opnd   = {{(STATE_W - SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg};
        w_load     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + STEP_W'(1);
                case (step_reg)
                    3'd0:
                    begin
                        mac_ctrl.mul_en = 1'b1;
                    end
                    3'd1:
                    begin
                        mac_ctrl = '{mul_en: 1'b1, acc_en: 1'b1, acc_load: 1'b1};
                        mac_coef = fb_coef_reg[1];
                        mac_opnd = tap_op[0];
                    end
                    3'd2:
                    begin
                        mac_ctrl = '{mul_en: 1'b1, acc_en: 1'b1, acc_load: 1'b0};
                        mac_coef = fb_coef_reg[2];
                        mac_opnd = tap_op[1];
                    end
                    3'd3:
                    begin
                        mac_ctrl = '{mul_en: 1'b1, acc_en: 1'b1, acc_load: 1'b0};
                        mac_coef = ff_coef_reg[1];
                        mac_opnd = tap_op[0];
                    end
                    3'd4:
                    begin
                        // acc holds the full w sum here; capture before reload
                        mac_ctrl = '{mul_en: 1'b1, acc_en: 1'b1, acc_load: 1'b1};
                        mac_coef = ff_coef_reg[2];
                        mac_opnd = tap_op[1];
                        w_load   = 1'b1;
                    end
                    3'd5:
                    begin
                        mac_ctrl = '{mul_en: 1'b1, acc_en: 1'b1, acc_load: 1'b0};
                        mac_coef = ff_coef_reg[0];
                        mac_opnd = w_reg;
                    end
                    3'd6:
                    begin
                        mac_ctrl = '{mul_en: 1'b0, acc_en: 1'b1, acc_load: 1'b0};
                    end
                    default:
                    begin
                        step_next = step_reg;
                        if (!m_valid_reg || m_tready)
                        begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_coef_reg[0] <= COEF_ONE;
            fb_coef_reg[1] <= '0;
            fb_coef_reg[2] <= '0;
            ff_coef_reg[0] <= COEF_ONE;
            ff_coef_reg[1] <= '0;
            ff_coef_reg[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FB_GAIN_0: fb_coef_reg[0] <= cfg_data;
                REG_FB_COEF_1: fb_coef_reg[1] <= cfg_data;
                REG_FB_COEF_2: fb_coef_reg[2] <= cfg_data;
                REG_FF_COEF_0: ff_coef_reg[0] <= cfg_data;
                REG_FF_COEF_1: ff_coef_reg[1] <= cfg_data;
                REG_FF_COEF_2: ff_coef_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
                dl_reg[i] <= '0;
        end
        else if (out_load)
        begin
            dl_reg[0] <= w_reg;
            for (int i = 1; i < ORDER; i++)
                dl_reg[i] <= dl_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            x_reg <= s_tdata;
        if (w_load)
        begin
            w_reg     <= w_sat;
            wclip_reg <= w_clip;
        end
        if (out_load)
        begin
            y_out_reg   <= y_sat;
            sat_out_reg <= wclip_reg || y_clip;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_TD_W - SAMPLE_W - 1)'(0), sat_out_reg, y_out_reg};

`ifndef SYNTHESIS
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == ST_RUN) && (step_reg == '0))
        else $error("sequencer did not start on input beat");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid && (m_tdata[SAMPLE_W-1:0] == $past(y_sat)))
        else $error("result beat not presented");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !out_load) |=> !m_tvalid)
        else $error("result beat repeated");

    a_wcap: assert property (@(posedge clk) disable iff (!rst_n)
        w_load |-> (state_reg == ST_RUN) && mac_ctrl.acc_load)
        else $error("w captured outside its step");
`endif

endmodule

/* src/iirdf2_mac.sv */
// ----------------------------------------------------------------------------
// iirdf2_mac
// Shared multiply-accumulate: registered product, then accumulator.
// ----------------------------------------------------------------------------
module iirdf2_mac
    import iirdf2_pkg::*;
(
    input  logic                     clk,
    input  mac_ctrl_t                ctrl,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [STATE_W-1:0] opnd,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb
    begin
        if (ctrl.acc_load)
            acc_next = ACC_W'(prod_reg);
        else
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            prod_reg <= coef * opnd;
        if (ctrl.acc_en)
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
